// File: rtl/core/scpf_pkg.sv
package scpf_pkg;

	localparam int unsigned MAX_PAYLOAD = 128;
	localparam logic [7:0] LEN_OVERHEAD = 8'd3;
	localparam logic [7:0] SEEN_SAT = 8'hFF;

	localparam logic [1:0] CFG_HEADER_WORD = 2'd0;
	localparam logic [1:0] CFG_MODULE_ADDRESS = 2'd1;
	localparam logic [1:0] CFG_COMMAND_FLAG = 2'd2;

	typedef struct packed {
		logic       start_packet;
		logic       end_packet;
		logic [7:0] command_code;
		logic [7:0] declared_length;
		logic       has_data;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] wire_byte;
		logic       packet_done;
		logic       length_error;
	} out_item_t;

	typedef struct packed {
		logic [15:0] header_word;
		logic [31:0] module_address;
		logic [7:0]  command_flag;
	} cfg_t;

	// One queued job: the per-item fields the back end needs to send one item's bytes.
	typedef struct packed {
		logic        start_en;
		logic        data_en;
		logic        end_en;
		logic [7:0]  code;
		logic [7:0]  len_hi;
		logic [7:0]  len_lo;
		logic [7:0]  data;
		logic [15:0] sum;
		logic        err;
	} job_t;

	typedef enum logic [3:0] {
		ST_HDR_HI,
		ST_HDR_LO,
		ST_ADR_3,
		ST_ADR_2,
		ST_ADR_1,
		ST_ADR_0,
		ST_FLAG,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_CODE,
		ST_DATA,
		ST_SUM_HI,
		ST_SUM_LO
	} step_t;

endpackage

// File: rtl/core/scpf_front.sv
module scpf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_stall,
	input  scpf_pkg::in_item_t item,
	input  scpf_pkg::cfg_t   cfg,
	output logic             push,
	output scpf_pkg::job_t   job
);
	import scpf_pkg::*;

	logic        in_packet_q;
	logic [15:0] sum_q;
	logic [7:0]  seen_q;
	logic [7:0]  exp_q;

	logic        accept;
	logic [7:0]  decl_sat;
	logic [8:0]  len_full;
	logic [7:0]  len_hi;
	logic [7:0]  len_lo;
	logic [15:0] start_sum;
	logic        active;
	logic [15:0] base_sum;
	logic [7:0]  base_seen;
	logic [7:0]  base_exp;
	logic        data_en;
	logic        end_en;
	logic [15:0] sum_next;
	logic [7:0]  seen_next;

	assign accept = item_valid && !item_stall;

	always_comb begin
		decl_sat = (item.declared_length > MAX_PAYLOAD[7:0]) ? MAX_PAYLOAD[7:0]
			: item.declared_length;
		len_full = {1'b0, decl_sat} + {1'b0, LEN_OVERHEAD};
		len_hi = {7'd0, len_full[8]};
		len_lo = len_full[7:0];
		start_sum = {8'd0, cfg.command_flag} + {8'd0, len_hi} + {8'd0, len_lo}
			+ {8'd0, item.command_code};
		active = item.start_packet || in_packet_q;
		base_sum = item.start_packet ? start_sum : sum_q;
		base_seen = item.start_packet ? 8'd0 : seen_q;
		base_exp = item.start_packet ? decl_sat : exp_q;
		// Bytes past the payload limit are counted but neither sent nor summed.
		data_en = active && item.has_data && (base_seen < MAX_PAYLOAD[7:0]);
		end_en = active && item.end_packet;
		sum_next = data_en ? base_sum + {8'd0, item.data_byte} : base_sum;
		seen_next = (active && item.has_data && base_seen != SEEN_SAT)
			? base_seen + 8'd1 : base_seen;

		job.start_en = item.start_packet;
		job.data_en = data_en;
		job.end_en = end_en;
		job.code = item.command_code;
		job.len_hi = len_hi;
		job.len_lo = len_lo;
		job.data = item.data_byte;
		job.sum = sum_next;
		job.err = (seen_next != base_exp);
	end

	assign push = accept && (item.start_packet || data_en || end_en);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			sum_q <= 16'd0;
			seen_q <= 8'd0;
			exp_q <= 8'd0;
		end else if (accept && active) begin
			if (end_en) begin
				in_packet_q <= 1'b0;
				sum_q <= 16'd0;
				seen_q <= 8'd0;
				exp_q <= 8'd0;
			end else begin
				in_packet_q <= 1'b1;
				sum_q <= sum_next;
				seen_q <= seen_next;
				exp_q <= base_exp;
			end
		end
	end

endmodule

// File: rtl/core/scpf_queue.sv
module scpf_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  scpf_pkg::job_t wr_job,
	input  logic           pop,
	output scpf_pkg::job_t rd_job,
	output logic           empty,
	output logic           full
);
	import scpf_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign empty = (count_q == '0);
	assign full = (count_q == FULL_CNT);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/scpf_back.sv
module scpf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  scpf_pkg::cfg_t      cfg,
	input  scpf_pkg::job_t      head,
	input  logic                empty,
	output logic                pop,
	output logic                tx_valid,
	input  logic                tx_stall,
	output scpf_pkg::out_item_t tx
);
	import scpf_pkg::*;

	logic      busy_q;
	step_t     step_q;
	logic      tx_valid_q;
	out_item_t tx_q;

	logic      load;
	logic      fire;
	step_t     cur_step;
	step_t     next_step;
	logic      last;
	out_item_t byte_d;

	assign load = !tx_valid_q || !tx_stall;
	assign fire = !empty && load;
	assign pop = fire && last;

	always_comb begin
		// A fresh job starts at its first enabled section.
		if (busy_q) begin
			cur_step = step_q;
		end else if (head.start_en) begin
			cur_step = ST_HDR_HI;
		end else if (head.data_en) begin
			cur_step = ST_DATA;
		end else begin
			cur_step = ST_SUM_HI;
		end

		next_step = cur_step;
		last = 1'b0;
		byte_d.packet_done = 1'b0;
		byte_d.length_error = 1'b0;
		case (cur_step)
			ST_HDR_HI: begin
				byte_d.wire_byte = cfg.header_word[15:8];
				next_step = ST_HDR_LO;
			end
			ST_HDR_LO: begin
				byte_d.wire_byte = cfg.header_word[7:0];
				next_step = ST_ADR_3;
			end
			ST_ADR_3: begin
				byte_d.wire_byte = cfg.module_address[31:24];
				next_step = ST_ADR_2;
			end
			ST_ADR_2: begin
				byte_d.wire_byte = cfg.module_address[23:16];
				next_step = ST_ADR_1;
			end
			ST_ADR_1: begin
				byte_d.wire_byte = cfg.module_address[15:8];
				next_step = ST_ADR_0;
			end
			ST_ADR_0: begin
				byte_d.wire_byte = cfg.module_address[7:0];
				next_step = ST_FLAG;
			end
			ST_FLAG: begin
				byte_d.wire_byte = cfg.command_flag;
				next_step = ST_LEN_HI;
			end
			ST_LEN_HI: begin
				byte_d.wire_byte = head.len_hi;
				next_step = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				byte_d.wire_byte = head.len_lo;
				next_step = ST_CODE;
			end
			ST_CODE: begin
				byte_d.wire_byte = head.code;
				if (head.data_en) begin
					next_step = ST_DATA;
				end else if (head.end_en) begin
					next_step = ST_SUM_HI;
				end else begin
					last = 1'b1;
				end
			end
			ST_DATA: begin
				byte_d.wire_byte = head.data;
				if (head.end_en) begin
					next_step = ST_SUM_HI;
				end else begin
					last = 1'b1;
				end
			end
			ST_SUM_HI: begin
				byte_d.wire_byte = head.sum[15:8];
				next_step = ST_SUM_LO;
			end
			ST_SUM_LO: begin
				byte_d.wire_byte = head.sum[7:0];
				byte_d.packet_done = 1'b1;
				byte_d.length_error = head.err;
				last = 1'b1;
			end
			default: begin
				byte_d.wire_byte = 8'd0;
				last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_HDR_HI;
			tx_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				busy_q <= !last;
				step_q <= next_step;
			end
			if (load) begin
				tx_valid_q <= fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			tx_q <= byte_d;
		end
	end

	assign tx_valid = tx_valid_q;
	assign tx = tx_q;

	a_pop_needs_fire: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> fire)
		else $error("job retired without sending its last byte");

	a_sum_pair: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cur_step == ST_SUM_HI |=> busy_q && step_q == ST_SUM_LO)
		else $error("checksum high byte not followed by low byte");

	a_busy_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !empty)
		else $error("job in progress but queue is empty");

	a_err_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid_q && tx_q.length_error |-> tx_q.packet_done)
		else $error("length error flagged on a byte other than the last");

endmodule

// File: rtl/core/sensor_command_packet_framer.sv
// Channel   Direction  Handshake               Payload
// item      in         item_valid / item_stall  in_item_t: one command item
// tx        out        tx_valid / tx_stall      out_item_t: one wire byte
// cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Items are taken one per cycle while the job queue has room; the back end
// sends one byte per cycle while tx_stall is low; a start item yields ten
// bytes, a payload byte one and a closing item two more. The input stalls
// only when the QUEUE_DEPTH-entry job queue is full. Reset clears the
// packet state, the queue and tx_valid and loads the default configuration.
module sensor_command_packet_framer #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  scpf_pkg::in_item_t  item,
	output logic                tx_valid,
	input  logic                tx_stall,
	output scpf_pkg::out_item_t tx,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import scpf_pkg::*;

	cfg_t cfg_q;
	logic push;
	job_t wr_job;
	job_t head;
	logic pop;
	logic empty;
	logic full;

	assign cfg_ready = 1'b1;
	assign item_stall = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_word <= 16'hEF01;
			cfg_q.module_address <= 32'hFFFF_FFFF;
			cfg_q.command_flag <= 8'h01;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HEADER_WORD: cfg_q.header_word <= cfg_data[15:0];
				CFG_MODULE_ADDRESS: cfg_q.module_address <= cfg_data;
				CFG_COMMAND_FLAG: cfg_q.command_flag <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	scpf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg        (cfg_q),
		.push       (push),
		.job        (wr_job)
	);

	scpf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (head),
		.empty  (empty),
		.full   (full)
	);

	scpf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.tx_valid (tx_valid),
		.tx_stall (tx_stall),
		.tx       (tx)
	);

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import scpf_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 64;
	localparam int RANDOM_PER_PHASE = 48;
	// The block defines nothing at this index; a write there must change nothing.
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic item_valid = 1'b0;
	logic item_stall;
	in_item_t item = '0;
	logic tx_valid;
	logic tx_stall = 1'b0;
	out_item_t tx;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	in_item_t items_to_send[$];
	out_item_t wire_bytes_due[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int fail_count = 0;
	int quiet_cycles = 0;

	// Predictor copy of the registers and the packet state.
	cfg_t cfg_shadow = '{header_word: 16'hEF01, module_address: 32'hFFFF_FFFF,
		command_flag: 8'h01};
	logic pkt_open = 1'b0;
	logic [15:0] pkt_sum = '0;
	logic [7:0] payload_seen = '0;
	logic [7:0] payload_declared = '0;

	sensor_command_packet_framer dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.tx_valid(tx_valid),
		.tx_stall(tx_stall),
		.tx(tx),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void due_byte(logic [7:0] b, logic done, logic err);
		wire_bytes_due.push_back('{wire_byte: b, packet_done: done, length_error: err});
	endfunction

	// Works out the wire bytes that one accepted item causes.
	task automatic frame_item(input in_item_t it);
		logic [7:0] decl;
		logic [15:0] len;
		if (it.start_packet) begin
			decl = (it.declared_length > MAX_PAYLOAD) ? 8'(MAX_PAYLOAD) : it.declared_length;
			len = {8'h00, decl} + {8'h00, LEN_OVERHEAD};
			due_byte(cfg_shadow.header_word[15:8], 1'b0, 1'b0);
			due_byte(cfg_shadow.header_word[7:0], 1'b0, 1'b0);
			due_byte(cfg_shadow.module_address[31:24], 1'b0, 1'b0);
			due_byte(cfg_shadow.module_address[23:16], 1'b0, 1'b0);
			due_byte(cfg_shadow.module_address[15:8], 1'b0, 1'b0);
			due_byte(cfg_shadow.module_address[7:0], 1'b0, 1'b0);
			due_byte(cfg_shadow.command_flag, 1'b0, 1'b0);
			due_byte(len[15:8], 1'b0, 1'b0);
			due_byte(len[7:0], 1'b0, 1'b0);
			due_byte(it.command_code, 1'b0, 1'b0);
			pkt_sum = {8'h00, cfg_shadow.command_flag} + {8'h00, len[15:8]}
				+ {8'h00, len[7:0]} + {8'h00, it.command_code};
			payload_seen = '0;
			payload_declared = decl;
			pkt_open = 1'b1;
		end
		if (!pkt_open)
			return;
		if (it.has_data) begin
			// Bytes past the payload limit are counted but neither sent nor summed.
			if (payload_seen < MAX_PAYLOAD) begin
				due_byte(it.data_byte, 1'b0, 1'b0);
				pkt_sum = pkt_sum + {8'h00, it.data_byte};
			end
			if (payload_seen != SEEN_SAT)
				payload_seen = payload_seen + 8'd1;
		end
		if (it.end_packet) begin
			due_byte(pkt_sum[15:8], 1'b0, 1'b0);
			due_byte(pkt_sum[7:0], 1'b1, payload_seen != payload_declared);
			pkt_open = 1'b0;
			pkt_sum = '0;
			payload_seen = '0;
			payload_declared = '0;
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_HEADER_WORD: cfg_shadow.header_word = cfg_data[15:0];
					CFG_MODULE_ADDRESS: cfg_shadow.module_address = cfg_data;
					CFG_COMMAND_FLAG: cfg_shadow.command_flag = cfg_data[7:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall)
				frame_item(item);
			if (tx_valid && !tx_stall) begin
				if (wire_bytes_due.size() == 0) begin
					$error("unexpected wire byte %02h", tx.wire_byte);
					fail_count++;
				end else begin
					want = wire_bytes_due.pop_front();
					if (tx.wire_byte !== want.wire_byte) begin
						$error("wire_byte: expected %02h, got %02h", want.wire_byte,
							tx.wire_byte);
						fail_count++;
					end
					if (tx.packet_done !== want.packet_done) begin
						$error("packet_done: expected %b, got %b", want.packet_done,
							tx.packet_done);
						fail_count++;
					end
					if (tx.length_error !== want.length_error) begin
						$error("length_error: expected %b, got %b", want.length_error,
							tx.length_error);
						fail_count++;
					end
				end
			end
		end
	end

	// Item driver and byte receiver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			tx_stall <= 1'b0;
		end else begin
			if (!item_valid || !item_stall) begin
				if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item <= items_to_send.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
			tx_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (tx_valid && !tx_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_item_t make_item(logic s, logic e, logic [7:0] code,
			logic [7:0] decl, logic has, logic [7:0] data);
		make_item = '{start_packet: s, end_packet: e, command_code: code,
			declared_length: decl, has_data: has, data_byte: data};
	endfunction

	function automatic in_item_t rand_item();
		rand_item = make_item(1'($urandom_range(1)), 1'($urandom_range(1)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)),
			8'($urandom_range(255)));
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every item is in and every byte is out, then lets the block settle.
	// The check runs on the falling edge, when the driver's updates have all landed.
	task automatic drain();
		while (items_to_send.size() != 0 || item_valid || wire_bytes_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One packet with random content; some declare the wrong length and a few are
	// abandoned without a closing item.
	task automatic queue_random_packet(input bit overflow, inout int queued);
		in_item_t it;
		logic [7:0] decl;
		int left;
		int pick;
		bit closes;
		bit closed;
		pick = $urandom_range(99);
		if (overflow) begin
			decl = 8'hFF;
			left = MAX_PAYLOAD + 2;
		end else if (pick < 60) begin
			decl = 8'($urandom_range(5));
			left = decl;
		end else if (pick < 80) begin
			decl = 8'($urandom_range(5));
			left = $urandom_range(6);
		end else begin
			decl = 8'($urandom_range(255));
			left = $urandom_range(6);
		end
		closes = overflow || ($urandom_range(19) != 0);
		it = rand_item();
		it.start_packet = 1'b1;
		it.declared_length = decl;
		it.has_data = (left > 0) && ($urandom_range(1) == 1);
		if (it.has_data)
			left--;
		it.end_packet = closes && left == 0 && ($urandom_range(1) == 1);
		closed = it.end_packet;
		items_to_send.push_back(it);
		queued++;
		while (left > 0) begin
			it = rand_item();
			it.start_packet = 1'b0;
			it.has_data = ($urandom_range(9) != 0);
			if (it.has_data)
				left--;
			it.end_packet = closes && left == 0 && ($urandom_range(1) == 1);
			closed = closed || it.end_packet;
			items_to_send.push_back(it);
			queued++;
		end
		if (closes && !closed) begin
			it = rand_item();
			it.start_packet = 1'b0;
			it.has_data = 1'b0;
			it.end_packet = 1'b1;
			items_to_send.push_back(it);
			queued++;
		end
	endtask

	task automatic run_random_phase(input int send_pct, input int stall_pct_v,
			input bit overflow);
		int queued;
		in_item_t it;
		queued = 0;
		send_idle_pct = send_pct;
		stall_pct = stall_pct_v;
		if (overflow)
			queue_random_packet(1'b1, queued);
		while (queued < RANDOM_PER_PHASE) begin
			if ($urandom_range(9) == 0) begin
				it = rand_item();
				it.start_packet = 1'b0;
				items_to_send.push_back(it);
			end
			queue_random_packet(1'b0, queued);
		end
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items on the reset configuration.
		items_to_send.push_back(make_item(1'b0, 1'b1, 8'h55, 8'h80, 1'b1, 8'hAA));
		items_to_send.push_back(make_item(1'b1, 1'b1, 8'h00, 8'h00, 1'b0, 8'h00));
		items_to_send.push_back(make_item(1'b1, 1'b1, 8'hFF, 8'h01, 1'b1, 8'hFF));
		items_to_send.push_back(make_item(1'b1, 1'b0, 8'hA5, 8'hFF, 1'b1, 8'h00));
		items_to_send.push_back(make_item(1'b0, 1'b0, 8'hFF, 8'hFF, 1'b0, 8'hFF));
		items_to_send.push_back(make_item(1'b0, 1'b1, 8'h00, 8'h00, 1'b0, 8'h00));
		items_to_send.push_back(make_item(1'b1, 1'b0, 8'h10, 8'h02, 1'b1, 8'h01));
		items_to_send.push_back(make_item(1'b0, 1'b0, 8'h00, 8'h00, 1'b1, 8'h80));
		// A new start abandons the open packet.
		items_to_send.push_back(make_item(1'b1, 1'b0, 8'h20, 8'h00, 1'b0, 8'h00));
		items_to_send.push_back(make_item(1'b0, 1'b1, 8'h00, 8'h00, 1'b1, 8'h7F));
		items_to_send.push_back(make_item(1'b1, 1'b0, 8'h31, 8'h03, 1'b0, 8'h00));
		items_to_send.push_back(make_item(1'b0, 1'b0, 8'h00, 8'h00, 1'b1, 8'h12));
		items_to_send.push_back(make_item(1'b0, 1'b0, 8'h00, 8'h00, 1'b1, 8'h34));
		items_to_send.push_back(make_item(1'b0, 1'b1, 8'h00, 8'h00, 1'b1, 8'h56));
		items_to_send.push_back(make_item(1'b0, 1'b0, 8'h00, 8'h00, 1'b1, 8'hC3));
		items_to_send.push_back(make_item(1'b1, 1'b1, 8'h01, 8'h81, 1'b0, 8'h00));
		items_to_send.push_back(make_item(1'b1, 1'b0, 8'h02, 8'h7F, 1'b1, 8'hFE));
		items_to_send.push_back(make_item(1'b0, 1'b1, 8'h00, 8'h00, 1'b0, 8'h00));
		drain();

		write_reg(CFG_HEADER_WORD, 32'h0000_0000);
		write_reg(CFG_MODULE_ADDRESS, 32'h0000_0000);
		write_reg(CFG_COMMAND_FLAG, 32'h0000_0000);
		run_random_phase(0, 0, 1'b0);

		write_reg(CFG_HEADER_WORD, 32'hFFFF_FFFF);
		write_reg(CFG_MODULE_ADDRESS, 32'hFFFF_FFFF);
		write_reg(CFG_COMMAND_FLAG, 32'hFFFF_FFFF);
		run_random_phase(84, 0, 1'b0);

		write_reg(CFG_HEADER_WORD, $urandom);
		write_reg(CFG_MODULE_ADDRESS, $urandom);
		write_reg(CFG_COMMAND_FLAG, $urandom);
		write_reg(CFG_UNUSED, $urandom);
		run_random_phase(0, 84, 1'b0);

		write_reg(CFG_MODULE_ADDRESS, $urandom);
		write_reg(CFG_COMMAND_FLAG, 32'h0000_00FF);
		run_random_phase(28, 28, 1'b1);

		write_reg(CFG_HEADER_WORD, $urandom);
		write_reg(CFG_MODULE_ADDRESS, $urandom);
		write_reg(CFG_COMMAND_FLAG, $urandom);
		run_random_phase(0, 0, 1'b0);

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
